// ===== hw/rtl/sgmg_pkg.sv =====
// shared types and constants for the sorted store with gap report
`timescale 1ns / 1ps

package sgmg_pkg;

    localparam int VALUE_W = 32;
    localparam int CAP_W   = 7;
    localparam int ECNT_W  = 7;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [VALUE_W-1:0] gap_t;

    // status one cell hands to its right-hand neighbour and to the top
    typedef struct packed {
        logic goes_left;  // held value stays put on insertion
        logic is_new;     // cell took the inserted value on the last transaction
    } cell_stat_t;

endpackage

// ===== hw/rtl/sgmg_item_if.sv =====
// input channel: one signed value per transaction
`timescale 1ns / 1ps

interface sgmg_item_if;
    import sgmg_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/sgmg_result_if.sv =====
// output channel: acceptance, count and span report per transaction
`timescale 1ns / 1ps

interface sgmg_result_if;
    import sgmg_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic [ECNT_W-1:0] element_count;
    logic              spans_valid;
    gap_t              shortest_gap;
    gap_t              longest_span;

    modport source (output valid, output accepted, output element_count,
                    output spans_valid, output shortest_gap, output longest_span,
                    input ready);
    modport sink   (input valid, input accepted, input element_count,
                    input spans_valid, input shortest_gap, input longest_span,
                    output ready);
endinterface

// ===== hw/rtl/sgmg_cell.sv =====
// one slot of the sorted chain: compare, hold or shift right, left-gap difference
`timescale 1ns / 1ps

module sgmg_cell
    import sgmg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,        // transaction accepted
    input  logic       ins,         // transaction accepted and there is room
    input  logic       occupied,    // slot index below the element count
    input  value_t     new_value,
    input  value_t     left_value,
    input  logic       left_goes,   // left neighbour keeps its value
    output value_t     held_value,
    output cell_stat_t stat,
    output gap_t       left_diff
);

    value_t val_reg;
    value_t val_next;
    logic   is_new_reg;
    logic   goes_left;
    logic   at_pos;

    // equal values stay left so the new one lands after them
    assign goes_left = occupied && (val_reg <= new_value);
    assign at_pos    = !goes_left && left_goes;

    always_comb
    begin
        val_next = val_reg;
        if (ins && !goes_left)
        begin
            val_next = at_pos ? new_value : left_value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_new_reg <= 1'b0;
        end
        else if (load)
        begin
            is_new_reg <= ins && at_pos;
        end
    end

    assign held_value     = val_reg;
    assign stat.goes_left = goes_left;
    assign stat.is_new    = is_new_reg;
    assign left_diff      = gap_t'(val_reg) - gap_t'(left_value);

endmodule

// ===== hw/rtl/sorted_store_min_max_gap.sv =====
// top level: bounded sorted multiset with smallest-gap and span report
// each transaction passes S_IDLE, then S_GAP. in the cycle a value is accepted every
// cell of the chain compares it with its own entry at once and either holds, takes
// the new value or takes its left neighbour's value, so the insertion completes in
// that same cycle. in S_GAP the block forms the differences to the two neighbours of
// the new entry, folds them into the running smallest gap and loads the result
// register; item.ready rises again after it. while an unread result still sits in
// the result register S_GAP waits while result.ready stays low. a finished result
// waits in its own register, so the next value can be accepted while the previous
// result is still unread. there is no clearing pass after reset: entries at or
// above the count are never reported. capacity is taken saturated at STORE_DEPTH;
// a full store refuses the value and reports the unchanged count and spans. gaps
// and span are exact unsigned differences, all ones while fewer than two elements
// are held
`timescale 1ns / 1ps

module sorted_store_min_max_gap
    import sgmg_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    sgmg_item_if.sink         item,
    sgmg_result_if.source     result,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic {S_IDLE, S_GAP} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CAP_W-1:0]   cap_reg;
    gap_t               min_gap_reg;
    value_t             max_reg;

    logic               out_valid_reg;
    logic               out_acc_reg;
    logic [ECNT_W-1:0]  out_count_reg;
    logic               out_spans_reg;
    gap_t               out_gap_reg;
    gap_t               out_span_reg;
    logic               acc_reg;     // accept flag carried into the gap cycle

    logic               load;
    logic               room;
    logic               ins;
    logic [CMP_W-1:0]   count_ext;

    // chain signals
    value_t             cell_val  [STORE_DEPTH];
    cell_stat_t         cell_stat [STORE_DEPTH];
    gap_t               cell_diff [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] cell_occ;

    // gap cycle
    gap_t               left_gap;
    gap_t               right_gap;
    logic               has_left;
    logic               has_right;
    gap_t               gap_next;
    logic               two_or_more;

    assign item.ready = (state_reg == S_IDLE);
    assign load       = item.valid && item.ready;
    assign count_ext  = CMP_W'(count_reg);

    // room when below both the written capacity and the physical depth
    assign room = (count_ext < CMP_W'(cap_reg)) && (count_ext < CMP_W'(STORE_DEPTH));
    assign ins  = load && room;

    // row of cells, each handing its value and status to the right
    for (genvar g = 0; g < STORE_DEPTH; g++)
    begin : g_cell
        assign cell_occ[g] = (count_reg > CNT_W'(g));

        if (g == 0)
        begin : g_first
            // the head cell sees an always-staying virtual neighbour
            sgmg_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (load),
                .ins        (ins),
                .occupied   (cell_occ[g]),
                .new_value  (item.value),
                .left_value (item.value),
                .left_goes  (1'b1),
                .held_value (cell_val[g]),
                .stat       (cell_stat[g]),
                .left_diff  (cell_diff[g])
            );
        end
        else
        begin : g_rest
            sgmg_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (load),
                .ins        (ins),
                .occupied   (cell_occ[g]),
                .new_value  (item.value),
                .left_value (cell_val[g-1]),
                .left_goes  (cell_stat[g-1].goes_left),
                .held_value (cell_val[g]),
                .stat       (cell_stat[g]),
                .left_diff  (cell_diff[g])
            );
        end
    end

    // pick the two differences that border the new entry; at most one cell
    // carries the new flag, so a masked or across the row selects them
    always_comb
    begin
        left_gap  = '0;
        right_gap = '0;
        has_left  = 1'b0;
        has_right = 1'b0;
        for (int i = 1; i < STORE_DEPTH; i++)
        begin
            if (cell_stat[i].is_new)
            begin
                left_gap = left_gap | cell_diff[i];
                has_left = 1'b1;
            end
            if (cell_stat[i-1].is_new && cell_occ[i])
            begin
                right_gap = right_gap | cell_diff[i];
                has_right = 1'b1;
            end
        end
    end

    always_comb
    begin
        gap_next = min_gap_reg;
        if (has_left && (left_gap < gap_next))
        begin
            gap_next = left_gap;
        end
        if (has_right && (right_gap < gap_next))
        begin
            gap_next = right_gap;
        end
    end

    assign two_or_more = (count_reg >= CNT_W'(2));

    // sequencer, running minimum and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= '0;
            min_gap_reg   <= '1;
            max_reg       <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_count_reg <= '0;
            out_spans_reg <= 1'b0;
            out_gap_reg   <= '1;
            out_span_reg  <= '1;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (load)
                    begin
                        acc_reg   <= room;
                        state_reg <= S_GAP;
                        if (room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            // new value lands after equal ones, so >= moves the maximum
                            if ((count_reg == '0) || (item.value >= max_reg))
                            begin
                                max_reg <= item.value;
                            end
                        end
                    end
                end
                S_GAP:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        min_gap_reg   <= gap_next;
                        out_valid_reg <= 1'b1;
                        out_acc_reg   <= acc_reg;
                        out_count_reg <= count_ext[ECNT_W-1:0];
                        out_spans_reg <= two_or_more;
                        out_gap_reg   <= two_or_more ? gap_next : '1;
                        out_span_reg  <= two_or_more ?
                                         (gap_t'(max_reg) - gap_t'(cell_val[0])) : '1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.accepted      = out_acc_reg;
    assign result.element_count = out_count_reg;
    assign result.spans_valid   = out_spans_reg;
    assign result.shortest_gap  = out_gap_reg;
    assign result.longest_span  = out_span_reg;

endmodule

// ===== hw/rtl/sgmg_checker.sv =====
// port-level checks on the sorted store, bound to the top level
`timescale 1ns / 1ps

module sgmg_checker
    import sgmg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic              res_accepted,
    input logic [ECNT_W-1:0] res_count,
    input logic              res_spans,
    input gap_t              res_gap,
    input gap_t              res_span
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_count) && $stable(res_gap)
            && $stable(res_span) && $stable(res_accepted) && $stable(res_spans))
        else $error("result changed while stalled");

    a_spans_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_spans == (res_count >= ECNT_W'(2))))
        else $error("span flag does not match element count");

    a_invalid_ones: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_spans |-> (res_gap == '1) && (res_span == '1))
        else $error("invalid spans not all ones");

    a_gap_le_span: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_spans |-> res_gap <= res_span)
        else $error("smallest gap exceeds span");

    a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_accepted |-> res_count != '0)
        else $error("accepted transaction with empty store");

endmodule

bind sorted_store_min_max_gap sgmg_checker u_sgmg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_accepted (result.accepted),
    .res_count    (result.element_count),
    .res_spans    (result.spans_valid),
    .res_gap      (result.shortest_gap),
    .res_span     (result.longest_span)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the sorted store with smallest-gap and span report
`timescale 1ns / 1ps

module testbench;
    import sgmg_pkg::*;

    localparam int     STORE_DEPTH   = 64;
    localparam value_t MOST_NEGATIVE = 32'h8000_0000;
    localparam value_t MOST_POSITIVE = 32'h7fff_ffff;
    localparam gap_t   NO_SPAN       = 32'hffff_ffff;

    // one report as the block should give it
    typedef struct packed {
        logic              accepted;
        logic [ECNT_W-1:0] element_count;
        logic              spans_valid;
        gap_t              shortest_gap;
        gap_t              longest_span;
    } span_report_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    sgmg_item_if   item_ch ();
    sgmg_result_if report_ch ();

    sorted_store_min_max_gap #(
        .STORE_DEPTH (STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (report_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the block state, kept in step with accepted transactions
    value_t           shadow_values[$];
    gap_t             shadow_min_gap = NO_SPAN;
    logic [CAP_W-1:0] shadow_capacity = '0;

    value_t       pending_values[$];
    span_report_t expected_reports[$];
    int           items_queued   = 0;
    int           items_accepted = 0;
    int           mismatch_count = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall pattern and the one long hold-off
    int rx_phase  = 0;
    int rx_mode   = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // insert one value into the shadow store and queue the report it must produce
    function automatic void insert_and_report(input value_t v);
        span_report_t r;
        int unsigned  room;
        int           pos;
        gap_t         g;
        room = (shadow_capacity > STORE_DEPTH) ? STORE_DEPTH : shadow_capacity;
        r.accepted = 1'b0;
        if (shadow_values.size() < room)
        begin
            // equal values go after the ones already held
            pos = 0;
            while (pos < shadow_values.size() && shadow_values[pos] <= v)
                pos++;
            shadow_values.insert(pos, v);
            r.accepted = 1'b1;
            if (pos > 0)
            begin
                g = gap_t'(v - shadow_values[pos-1]);
                if (g < shadow_min_gap)
                    shadow_min_gap = g;
            end
            if (pos + 1 < shadow_values.size())
            begin
                g = gap_t'(shadow_values[pos+1] - v);
                if (g < shadow_min_gap)
                    shadow_min_gap = g;
            end
        end
        r.element_count = ECNT_W'(shadow_values.size());
        if (shadow_values.size() >= 2)
        begin
            r.spans_valid  = 1'b1;
            r.shortest_gap = shadow_min_gap;
            r.longest_span = gap_t'(shadow_values[$] - shadow_values[0]);
        end
        else
        begin
            r.spans_valid  = 1'b0;
            r.shortest_gap = NO_SPAN;
            r.longest_span = NO_SPAN;
        end
        expected_reports.push_back(r);
    endfunction

    // values clustered within 16 times the spread around zero, some near held entries, some wild, some in -1..2
    function automatic value_t pick_value(input int unsigned spread);
        value_t      v;
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 2)
            v = value_t'($urandom);
        else if (k < 6)
            v = value_t'($urandom_range(0, 32 * spread)) - value_t'(16 * spread);
        else if (k < 9 && shadow_values.size() != 0)
        begin
            v = shadow_values[$urandom_range(0, shadow_values.size() - 1)];
            if ($urandom_range(0, 1) == 1)
                v = v + value_t'($urandom_range(1, spread));
            else
                v = v - value_t'($urandom_range(1, spread));
        end
        else
            v = value_t'($urandom_range(0, 3)) - value_t'(1);
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
    endtask

    task automatic offer(input value_t v);
        pending_values.push_back(v);
        items_queued++;
    endtask

    // wait until every offered item has been taken and reported, then let it settle
    task automatic drain_pipeline();
        while (items_accepted != items_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_capacity = c;
    endtask

    // item driver: bursts of offers with random gaps, value held until taken
    always @(posedge clk)
    begin : drive_items
        bit stalled;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                insert_and_report(item_ch.value);
                items_accepted++;
            end
            stalled = item_ch.valid && !item_ch.ready;
            if (!stalled)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.value <= pending_values.pop_front();
                    if (burst_left <= 1)
                    begin
                        // new burst; a quarter of them follow on with no gap at all
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once a large batch is waiting to be sent
    always @(posedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (!hold_used && pending_values.size() > 40)
            begin
                hold_used <= 1'b1;
                hold_left <= 400;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // receiver: ready follows a randomly redrawn stall pattern, held low during the long hold-off
    always @(posedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            report_ch.ready <= 1'b0;
        end
        else
        begin
            rx_phase++;
            if (rx_phase % 96 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left != 0)
                report_ch.ready <= 1'b0;
            else
                case (rx_mode)
                    0:       report_ch.ready <= 1'b1;
                    1:       report_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       report_ch.ready <= (rx_phase % 4 == 0);
                    default: report_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
        end
    end

    // monitor: every report taken is checked against the oldest expectation
    always @(posedge clk)
    begin : check_reports
        span_report_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("unexpected transaction", report_ch.element_count, '0);
            else
            begin
                want = expected_reports.pop_front();
                if (report_ch.accepted !== want.accepted)
                    report_mismatch("accepted", report_ch.accepted, want.accepted);
                if (report_ch.element_count !== want.element_count)
                    report_mismatch("element_count", report_ch.element_count,
                                    want.element_count);
                if (report_ch.spans_valid !== want.spans_valid)
                    report_mismatch("spans_valid", report_ch.spans_valid, want.spans_valid);
                if (report_ch.shortest_gap !== want.shortest_gap)
                    report_mismatch("shortest_gap", report_ch.shortest_gap, want.shortest_gap);
                if (report_ch.longest_span !== want.longest_span)
                    report_mismatch("longest_span", report_ch.longest_span, want.longest_span);
            end
        end
    end

    // stimulus sequence; the store is never cleared, so spread and extremes are ordered
    initial
    begin : stimulus
        logic [CAP_W-1:0] phase_caps [9];
        int               p;
        int unsigned      spread;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        phase_caps = '{7'd8, 7'd12, 7'd16, 7'd24, 7'd32, 7'd40, 7'd48, 7'd56, 7'd60};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero capacity: everything refused, no spans
        write_capacity(7'd0);
        offer(100);
        offer(-100);
        drain_pipeline();

        // a single element still gives no spans
        write_capacity(7'd1);
        offer(1000);
        offer(5);
        drain_pipeline();

        write_capacity(7'd3);
        offer(-3000);
        offer(5000);
        offer(7);
        drain_pipeline();

        // capacity lowered below the count: elements kept, new ones refused
        write_capacity(7'd2);
        offer(11);
        offer(-11);
        drain_pipeline();

        // random phases, capacity rising while values tighten to shrink the gaps
        for (p = 0; p < 9; p++)
        begin
            write_capacity(phase_caps[p]);
            spread = 1 << (24 - 2 * p);
            repeat (55) offer(pick_value(spread));
            drain_pipeline();
        end

        // capacity above the depth saturates; extremes give an all-ones span,
        // a duplicate gives a zero gap
        write_capacity(7'd127);
        offer(MOST_NEGATIVE);
        offer(MOST_POSITIVE);
        offer(shadow_values[shadow_values.size() / 2]);
        offer(MOST_POSITIVE);
        repeat (40) offer(value_t'($urandom));
        drain_pipeline();

        write_capacity(7'd64);
        repeat (15) offer(value_t'($urandom));
        drain_pipeline();

        write_capacity(7'd0);
        repeat (10) offer(value_t'($urandom));
        drain_pipeline();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sgmg_pkg.sv
hw/rtl/sgmg_item_if.sv
hw/rtl/sgmg_result_if.sv
hw/rtl/sgmg_cell.sv
hw/rtl/sorted_store_min_max_gap.sv
hw/rtl/sgmg_checker.sv
tb/sv/testbench.sv
